[sv/czm_pkg.sv]
// Shared types, register indexes and helpers of the centre zoom move generator.
package czm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int COORD_W    = 10;
  localparam int DIV_W      = 12;
  localparam int DIV_CNT_W  = 4;

  localparam logic [7:0] RATIO_UNITY = 8'd16;
  localparam logic [7:0] ZERO_RATIO_QUOT = 8'hFF;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ORIGIN_X      = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y      = 3'd1;
  localparam cfg_idx_t CFG_REGION_WIDTH  = 3'd2;
  localparam cfg_idx_t CFG_REGION_HEIGHT = 3'd3;
  localparam cfg_idx_t CFG_RATIO_X       = 3'd4;
  localparam cfg_idx_t CFG_RATIO_Y       = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Magnitude of an 8-bit two's complement offset, scaled by 16.
  function automatic logic [DIV_W-1:0] scaled_mag(input logic [7:0] off);
    logic [7:0] mag;
    begin
      mag = off[7] ? (~off + 8'd1) : off;
      scaled_mag = {mag, 4'b0000};
    end
  endfunction

  // Applies the sign to the quotient and keeps its low byte; a zero ratio gives all ones.
  function automatic logic [7:0] quot_byte(input logic [DIV_W-1:0] q, input logic neg,
                                           input logic [7:0] ratio);
    logic [DIV_W-1:0] sq;
    begin
      sq = neg ? (~q + DIV_W'(1)) : q;
      quot_byte = (ratio == 8'd0) ? ZERO_RATIO_QUOT : sq[7:0];
    end
  endfunction

endpackage

[sv/czm_in_if.sv]
// Input channel: one step request per transaction.
interface czm_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

[sv/czm_out_if.sv]
// Result channel: one pixel move per transaction.
interface czm_out_if;
  logic            valid;
  logic            ready;
  czm_pkg::coord_t dst_x;
  czm_pkg::coord_t dst_y;
  czm_pkg::coord_t src_x;
  czm_pkg::coord_t src_y;
  logic            last_of_item;
  logic            scan_done;

  modport source (output valid, output dst_x, output dst_y, output src_x, output src_y,
                  output last_of_item, output scan_done, input ready);
  modport sink (input valid, input dst_x, input dst_y, input src_x, input src_y,
                input last_of_item, input scan_done, output ready);
endinterface

[sv/czm_cfg_if.sv]
// Configuration write channel: register index and write data.
interface czm_cfg_if;
  logic                               valid;
  logic                               ready;
  czm_pkg::cfg_idx_t                  index;
  logic [czm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/centre_zoom_move_generator_top.sv]
// Centre zoom move generator: scan sequencer, shared serial divider and move output.
// An accepted step passes through the x divide and the y divide before its first move is
// offered, then four moves follow; output stalls hold them. No new step is taken until the
// last move is taken; the single restoring divider yields one quotient bit a cycle.
// A step that meets a finished scan without restart yields no moves; the block stays idle.
// Reset (rst_n low, synchronous) clears the scan and sets the registers to their defaults.
module centre_zoom_move_generator_top (
  input  logic       clk,
  input  logic       rst_n,
  czm_in_if.sink     in_ch,
  czm_out_if.source  out_ch,
  czm_cfg_if.sink    cfg_ch
);

  logic [7:0] origin_x_r, origin_y_r, region_width_r, region_height_r;
  logic [7:0] ratio_x_r, ratio_y_r;

  czm_pkg::state_t state_r, state_nxt;
  logic [czm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic       phase_r, phase_nxt;
  logic [1:0] k_r, k_nxt;
  logic [7:0] row_r, row_nxt, col_r, col_nxt;
  logic       fin_r, fin_nxt;
  logic       done_r, done_nxt;
  logic [7:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [7:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic [7:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [czm_pkg::DIV_W-1:0] dvd_r, dvd_nxt;

  logic       in_acc;
  logic [6:0] half_w, half_h;
  logic [7:0] row_eff, col_eff, xs_new, ys_new, divisor;
  logic       fin_eff, last_col, last_row;
  logic [8:0] trial;
  logic       q_bit;
  logic [7:0] rem_step;
  logic [czm_pkg::DIV_W-1:0] dvd_step;
  czm_pkg::coord_t xc_w, yc_w, xs_w, ys_w, x1_w, y1_w;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= 8'd0;
      origin_y_r      <= 8'd0;
      region_width_r  <= 8'd0;
      region_height_r <= 8'd0;
      ratio_x_r       <= czm_pkg::RATIO_UNITY;
      ratio_y_r       <= czm_pkg::RATIO_UNITY;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        czm_pkg::CFG_ORIGIN_X:      origin_x_r      <= cfg_ch.data;
        czm_pkg::CFG_ORIGIN_Y:      origin_y_r      <= cfg_ch.data;
        czm_pkg::CFG_REGION_WIDTH:  region_width_r  <= cfg_ch.data;
        czm_pkg::CFG_REGION_HEIGHT: region_height_r <= cfg_ch.data;
        czm_pkg::CFG_RATIO_X:       ratio_x_r       <= cfg_ch.data;
        czm_pkg::CFG_RATIO_Y:       ratio_y_r       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == czm_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign half_w   = region_width_r[7:1];
  assign half_h   = region_height_r[7:1];
  assign row_eff  = in_ch.restart ? 8'd0 : row_r;
  assign col_eff  = in_ch.restart ? 8'd0 : col_r;
  assign fin_eff  = in_ch.restart ? 1'b0 : fin_r;
  assign last_col = (col_eff >= {1'b0, half_w});
  assign last_row = (row_eff >= {1'b0, half_h});
  assign xs_new   = (ratio_x_r > czm_pkg::RATIO_UNITY) ? ({1'b0, half_w} - col_eff) : col_eff;
  assign ys_new   = (ratio_y_r > czm_pkg::RATIO_UNITY) ? ({1'b0, half_h} - row_eff) : row_eff;

  // One restoring divide step: the remainder stays below the divisor unless the divisor is zero.
  assign divisor  = phase_r ? ratio_y_r : ratio_x_r;
  assign trial    = {rem_r, dvd_r[czm_pkg::DIV_W-1]};
  assign q_bit    = (trial >= {1'b0, divisor});
  assign rem_step = q_bit ? 8'(trial - {1'b0, divisor}) : trial[7:0];
  assign dvd_step = {dvd_r[czm_pkg::DIV_W-2:0], q_bit};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    fin_nxt   = fin_r;
    done_nxt  = done_r;
    xc_nxt    = xc_r;
    yc_nxt    = yc_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    x1_nxt    = x1_r;
    y1_nxt    = y1_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    case (state_r)
      czm_pkg::ST_IDLE: begin
        if (in_acc) begin
          row_nxt = row_eff;
          col_nxt = col_eff;
          fin_nxt = fin_eff;
          if (!fin_eff) begin
            xc_nxt    = origin_x_r + {1'b0, half_w};
            yc_nxt    = origin_y_r + {1'b0, half_h};
            xs_nxt    = xs_new;
            ys_nxt    = ys_new;
            done_nxt  = last_col && last_row;
            rem_nxt   = 8'd0;
            dvd_nxt   = czm_pkg::scaled_mag(xs_new);
            cnt_nxt   = '0;
            phase_nxt = 1'b0;
            state_nxt = czm_pkg::ST_DIV;
            if (last_col) begin
              col_nxt = 8'd0;
              if (last_row) begin
                fin_nxt = 1'b1;
              end else begin
                row_nxt = row_eff + 8'd1;
              end
            end else begin
              col_nxt = col_eff + 8'd1;
            end
          end
        end
      end
      czm_pkg::ST_DIV: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == czm_pkg::DIV_CNT_W'(czm_pkg::DIV_W - 1)) begin
          cnt_nxt = '0;
          if (!phase_r) begin
            x1_nxt    = czm_pkg::quot_byte(dvd_step, xs_r[7], ratio_x_r);
            rem_nxt   = 8'd0;
            dvd_nxt   = czm_pkg::scaled_mag(ys_r);
            phase_nxt = 1'b1;
          end else begin
            y1_nxt    = czm_pkg::quot_byte(dvd_step, ys_r[7], ratio_y_r);
            k_nxt     = 2'd0;
            state_nxt = czm_pkg::ST_EMIT;
          end
        end
      end
      czm_pkg::ST_EMIT: begin
        if (out_ch.ready) begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = czm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = czm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= czm_pkg::ST_IDLE;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      k_r     <= 2'd0;
      row_r   <= 8'd0;
      col_r   <= 8'd0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      fin_r   <= fin_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xc_r  <= xc_nxt;
    yc_r  <= yc_nxt;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    x1_r  <= x1_nxt;
    y1_r  <= y1_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  // Quadrant order: bit 0 of the move count mirrors columns, bit 1 mirrors rows.
  assign xc_w = czm_pkg::coord_t'({2'b00, xc_r});
  assign yc_w = czm_pkg::coord_t'({2'b00, yc_r});
  assign xs_w = czm_pkg::coord_t'({{2{xs_r[7]}}, xs_r});
  assign ys_w = czm_pkg::coord_t'({{2{ys_r[7]}}, ys_r});
  assign x1_w = czm_pkg::coord_t'({2'b00, x1_r});
  assign y1_w = czm_pkg::coord_t'({2'b00, y1_r});

  assign out_ch.valid        = (state_r == czm_pkg::ST_EMIT);
  assign out_ch.dst_x        = k_r[0] ? (xc_w - xs_w) : (xc_w + xs_w);
  assign out_ch.dst_y        = k_r[1] ? (yc_w - ys_w) : (yc_w + ys_w);
  assign out_ch.src_x        = k_r[0] ? (xc_w - x1_w) : (xc_w + x1_w);
  assign out_ch.src_y        = k_r[1] ? (yc_w - y1_w) : (yc_w + y1_w);
  assign out_ch.last_of_item = (k_r == 2'd3);
  assign out_ch.scan_done    = (k_r == 2'd3) && done_r;

endmodule

[sv/czm_checker.sv]
// Port-level checks of the centre zoom move generator, bound to the top level.
module czm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input czm_pkg::coord_t out_dst_x,
  input logic            out_last_of_item,
  input logic            out_scan_done
);

  // No new step is taken while moves of the previous one are still on offer.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("step accepted while moves pending");

  // The step first goes through the divide, so no move follows a step at once.
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !out_valid)
    else $error("move appeared directly after a step");

  // The four moves of a step are offered without gaps.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_ready && !out_last_of_item) |=> out_valid)
    else $error("gap inside the moves of one step");

  // A stalled move stays offered with its destination x unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_ready) |=> (out_valid && $stable(out_dst_x)))
    else $error("stalled move changed");

  // The end of the scan is flagged only on the closing move of a step.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_scan_done) |-> out_last_of_item)
    else $error("scan end flagged mid-step");

endmodule

bind centre_zoom_move_generator_top czm_checker u_czm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_dst_x        (out_ch.dst_x),
  .out_last_of_item (out_ch.last_of_item),
  .out_scan_done    (out_ch.scan_done)
);

[tb/czm_move_checker.sv]
// Checker for the centre zoom move generator: predicts every pixel move and compares.
`timescale 1ns / 1ps

module czm_move_checker (
  input  logic        clk,
  input  logic        rst_n,
  czm_in_if           in_ch,
  czm_out_if          out_ch,
  czm_cfg_if          cfg_ch,
  output int unsigned mismatches,
  output int unsigned moves_pending
);
  import czm_pkg::*;

  typedef struct packed {
    coord_t dst_x;
    coord_t dst_y;
    coord_t src_x;
    coord_t src_y;
    logic   last_of_item;
    logic   scan_done;
  } move_t;

  logic [7:0]  org_x, org_y, reg_w, reg_h, zoom_x, zoom_y;
  logic [7:0]  row_idx, col_idx;
  logic        scan_over;
  move_t       move_q[$];
  int unsigned mism;

  // Source offset in sixteenths of the zoom ratio, truncated towards zero, low byte kept.
  function automatic logic [7:0] zoom_offset(input logic [7:0] off, input logic [7:0] ratio);
    int q;
    if (ratio == 8'd0) return ZERO_RATIO_QUOT;
    q = (int'($signed(off)) * 16) / int'(ratio);
    return q[7:0];
  endfunction

  function automatic void push_move(input int dx, input int dy, input int sx, input int sy,
                                    input logic last, input logic done);
    move_t mv;
    mv.dst_x        = dx[COORD_W-1:0];
    mv.dst_y        = dy[COORD_W-1:0];
    mv.src_x        = sx[COORD_W-1:0];
    mv.src_y        = sy[COORD_W-1:0];
    mv.last_of_item = last;
    mv.scan_done    = done;
    move_q.push_back(mv);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mism++;
    end
  endfunction

  task automatic apply_write(input cfg_idx_t idx, input logic [7:0] val);
    case (idx)
      CFG_ORIGIN_X:      org_x = val;
      CFG_ORIGIN_Y:      org_y = val;
      CFG_REGION_WIDTH:  reg_w = val;
      CFG_REGION_HEIGHT: reg_h = val;
      CFG_RATIO_X:       zoom_x = val;
      CFG_RATIO_Y:       zoom_y = val;
      default: ;
    endcase
  endtask

  task automatic predict_step(input logic restart);
    logic [7:0] half_w, half_h, xc, yc, xs, ys, x1, y1;
    logic       last_col, last_row;
    int         cx, cy, dxs, dys, sxs, sys;
    half_w = reg_w >> 1;
    half_h = reg_h >> 1;
    if (restart) begin
      row_idx   = 8'd0;
      col_idx   = 8'd0;
      scan_over = 1'b0;
    end
    if (!scan_over) begin
      xc = org_x + half_w;
      yc = org_y + half_h;
      // Above unity the scan runs from the rim inwards.
      ys = (zoom_y > RATIO_UNITY) ? half_h - row_idx : row_idx;
      xs = (zoom_x > RATIO_UNITY) ? half_w - col_idx : col_idx;
      y1 = zoom_offset(ys, zoom_y);
      x1 = zoom_offset(xs, zoom_x);
      last_col = col_idx >= half_w;
      last_row = row_idx >= half_h;
      cx  = int'(xc);
      cy  = int'(yc);
      dxs = int'($signed(xs));
      dys = int'($signed(ys));
      sxs = int'(x1);
      sys = int'(y1);
      push_move(cx + dxs, cy + dys, cx + sxs, cy + sys, 1'b0, 1'b0);
      push_move(cx - dxs, cy + dys, cx - sxs, cy + sys, 1'b0, 1'b0);
      push_move(cx + dxs, cy - dys, cx + sxs, cy - sys, 1'b0, 1'b0);
      push_move(cx - dxs, cy - dys, cx - sxs, cy - sys, 1'b1, last_col && last_row);
      if (last_col) begin
        col_idx = 8'd0;
        if (last_row) scan_over = 1'b1;
        else row_idx = row_idx + 8'd1;
      end else begin
        col_idx = col_idx + 8'd1;
      end
    end
  endtask

  task automatic check_move();
    move_t want;
    if (move_q.size() == 0) begin
      $error("move transaction arrived with no move expected");
      mism++;
    end else begin
      want = move_q.pop_front();
      check_field("dst_x", int'($signed(want.dst_x)), int'($signed(out_ch.dst_x)));
      check_field("dst_y", int'($signed(want.dst_y)), int'($signed(out_ch.dst_y)));
      check_field("src_x", int'($signed(want.src_x)), int'($signed(out_ch.src_x)));
      check_field("src_y", int'($signed(want.src_y)), int'($signed(out_ch.src_y)));
      check_field("last_of_item", int'(want.last_of_item), int'(out_ch.last_of_item));
      check_field("scan_done", int'(want.scan_done), int'(out_ch.scan_done));
    end
  endtask

  initial begin
    mism = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      org_x     = 8'd0;
      org_y     = 8'd0;
      reg_w     = 8'd0;
      reg_h     = 8'd0;
      zoom_x    = RATIO_UNITY;
      zoom_y    = RATIO_UNITY;
      row_idx   = 8'd0;
      col_idx   = 8'd0;
      scan_over = 1'b0;
      move_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_write(cfg_ch.index, cfg_ch.data);
      if (out_ch.valid && out_ch.ready) check_move();
      if (in_ch.valid && in_ch.ready) predict_step(in_ch.restart);
    end
    mismatches    <= mism;
    moves_pending <= move_q.size();
  end

endmodule

[tb/tb_centre_zoom_move_generator_top.sv]
// Testbench top: clock, reset, step and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_centre_zoom_move_generator_top;
  import czm_pkg::*;

  localparam int TOTAL_STEPS     = 280;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_PCT        = 22;
  localparam int RESTART_PCT     = 8;
  localparam int CALM_PHASE      = 2;
  localparam int HOLD_PHASE      = 4;

  logic        clk;
  logic        rst_n;
  logic        step_taken  = 1'b0;
  logic        write_taken = 1'b0;
  bit          calm;
  bit          hold_off_req;
  bit          hold_off_done;
  int unsigned cycles;
  int unsigned steps_sent;
  int unsigned mismatches, moves_pending;

  czm_in_if  in_ch();
  czm_out_if out_ch();
  czm_cfg_if cfg_ch();

  centre_zoom_move_generator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  czm_move_checker move_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .moves_pending (moves_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshakes seen at the rising edge, read by the drivers at the following falling edge.
  always @(posedge clk) begin
    step_taken  <= in_ch.valid && in_ch.ready;
    write_taken <= cfg_ch.valid && cfg_ch.ready;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Move receiver: random stalls, none in the calm phase, and one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Called at a falling edge; valid is left high so that the next transaction may follow.
  task automatic send_step(input logic rs);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= rs;
    do @(negedge clk); while (!step_taken);
    steps_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!write_taken);
  endtask

  task automatic write_regs(input logic [7:0] ox, input logic [7:0] oy, input logic [7:0] w,
                            input logic [7:0] h, input logic [7:0] rx, input logic [7:0] ry);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_REGION_WIDTH, w);
    write_reg(CFG_REGION_HEIGHT, h);
    write_reg(CFG_RATIO_X, rx);
    write_reg(CFG_RATIO_Y, ry);
    cfg_ch.valid <= 1'b0;
  endtask

  // A step on a finished scan yields no move, so SETTLE_CYCLES more pass once all moves are in.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (moves_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_size();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return 8'($urandom_range(12));
  endfunction

  function automatic logic [7:0] pick_ratio();
    case ($urandom_range(5))
      0:       return 8'd1;
      1:       return RATIO_UNITY - 8'd1;
      2:       return RATIO_UNITY;
      3:       return RATIO_UNITY + 8'd1;
      4:       return 8'd255;
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  initial begin
    int          phase;
    int          n;
    bit          fresh;
    logic [7:0]  w, h;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.restart  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_ORIGIN_X;
    cfg_ch.data    = 8'd0;
    calm           = 1'b0;
    hold_off_req   = 1'b0;
    hold_off_done  = 1'b0;
    steps_sent     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: an empty region is a one-position scan, then the scan is finished.
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b1);
    settle();

    // Every register at its top value; the rim-inwards scan wraps the coordinates.
    write_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();

    // Smallest nonzero ratio; the last step meets a finished scan.
    write_regs(8'd0, 8'd0, 8'd3, 8'd2, 8'd1, 8'd1);
    send_step(1'b1);
    repeat (4) send_step(1'b0);
    settle();

    // Zero ratio forces the quotient to all ones.
    write_regs(8'd100, 8'd60, 8'd4, 8'd2, 8'd0, 8'd0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();

    // Into the second row, then the region shrinks under the scan.
    write_regs(8'd10, 8'd20, 8'd6, 8'd6, 8'd200, RATIO_UNITY + 8'd1);
    send_step(1'b1);
    repeat (4) send_step(1'b0);
    settle();
    write_regs(8'd10, 8'd20, 8'd0, 8'd0, 8'd200, RATIO_UNITY + 8'd1);
    send_step(1'b0);
    send_step(1'b0);
    settle();

    phase = 0;
    while (steps_sent < TOTAL_STEPS) begin
      calm  = (phase == CALM_PHASE);
      fresh = ($urandom_range(99) < 70) || (phase == HOLD_PHASE);
      n     = calm ? 40 : $urandom_range(40, 10);
      w     = pick_size();
      h     = pick_size();
      if (phase == HOLD_PHASE) begin
        // A large region keeps every step productive while the receiver holds off.
        w            = 8'd200;
        h            = 8'd200;
        n            = 30;
        hold_off_req = 1'b1;
      end
      write_regs(8'($urandom_range(255)), 8'($urandom_range(255)), w, h,
                 pick_ratio(), pick_ratio());
      for (int i = 0; i < n; i++) begin
        send_step((fresh && i == 0) || ($urandom_range(99) < RESTART_PCT));
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    if (mismatches == 0 && moves_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[centre_zoom_move_generator_top.f]
sv/czm_pkg.sv
sv/czm_in_if.sv
sv/czm_out_if.sv
sv/czm_cfg_if.sv
sv/centre_zoom_move_generator_top.sv
sv/czm_checker.sv
tb/czm_move_checker.sv
tb/tb_centre_zoom_move_generator_top.sv
